@@ rtl/mrfc_pkg.sv @@
// Shared types, constants and the CRC-16 byte step for the meter response frame checker.
// Used by mrfc_frame_unit and meter_response_frame_checker_core; depends on nothing else.
package mrfc_pkg;

  // Field widths.
  localparam int unsigned AddrW   = 27;
  localparam int unsigned IdW     = 16;
  localparam int unsigned SizeW   = 4;
  localparam int unsigned CountW  = 5;
  localparam int unsigned SumW    = 28;
  localparam int unsigned ValueW  = 64;
  localparam int unsigned StatusW = 4;
  localparam int unsigned CfgIdxW = 2;

  // Default for the payload length parameter.
  localparam int unsigned MaxPayloadDefault = 8;

  // CRC-16 settings: initial value and reflected polynomial.
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // Frame shape constants.
  localparam logic [CountW-1:0] MinFrameLen  = 5'd6;
  localparam logic [CountW-1:0] ErrFrameLen  = 5'd11;
  localparam logic [CountW-1:0] FrameOverhead = 5'd10;
  localparam logic [7:0]        FuncError    = 8'h00;
  localparam logic [7:0]        MaxDevCode   = 8'd8;
  localparam logic [7:0]        DevCodePermA = 8'd2;
  localparam logic [7:0]        DevCodePermB = 8'd4;

  // Input item kinds carried on the slave-side tuser bit.
  localparam logic CmdByte = 1'b0;
  localparam logic CmdGap  = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegSlaveAddress = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRequestId    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPayloadSize  = 2'd2;

  // Result status codes.
  localparam logic [StatusW-1:0] StOk        = 4'd0;
  localparam logic [StatusW-1:0] StShort     = 4'd1;
  localparam logic [StatusW-1:0] StBadEnd    = 4'd2;
  localparam logic [StatusW-1:0] StBadLength = 4'd3;
  localparam logic [StatusW-1:0] StCrc       = 4'd4;
  localparam logic [StatusW-1:0] StAddress   = 4'd5;
  localparam logic [StatusW-1:0] StId        = 4'd6;
  localparam logic [StatusW-1:0] StDevError  = 4'd7;
  localparam logic [StatusW-1:0] StDevCode   = 4'd8;

  // Configuration register set.
  typedef struct packed {
    logic [AddrW-1:0] slave_address;
    logic [IdW-1:0]   request_id;
    logic [SizeW-1:0] payload_size;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic [ValueW-1:0]  value;
    logic               permanent;
    logic [7:0]         device_error;
    logic [StatusW-1:0] status;
  } result_t;

  // Width of the packed output tdata: fields rounded up to whole bytes.
  localparam int unsigned ResultW = ValueW + 1 + 8 + StatusW;
  localparam int unsigned OutDataW = ((ResultW + 7) / 8) * 8;

  // One byte step of the reflected CRC-16, eight bit steps.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] w;
    w = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (w[0]) begin
        w = (w >> 1) ^ CrcPoly;
      end else begin
        w = w >> 1;
      end
    end
    return w;
  endfunction

endpackage

@@ rtl/mrfc_frame_unit.sv @@
// Frame state and end-of-frame checks for the meter response frame checker.
// Depends on mrfc_pkg for types, constants and the CRC-16 byte step.
module mrfc_frame_unit
  import mrfc_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MaxPayloadDefault
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    in_fire,
  input  logic    cmd,
  input  logic [7:0] rx_byte,
  output logic    res_valid,
  output result_t res
);

  localparam int unsigned PayW = 8 * MAX_PAYLOAD;

  // Frame state.
  logic [CountW-1:0] byte_count;
  logic [15:0]       running_crc;
  logic [7:0]        recent_bytes [4];
  logic [7:0]        function_byte;
  logic [7:0]        length_byte;
  logic [7:0]        error_byte;
  logic [SumW-1:0]   address_sum;
  logic [PayW-1:0]   payload_value;

  // State after taking the current byte.
  logic [CountW-1:0] byte_count_next;
  logic [15:0]       running_crc_next;
  logic [7:0]        recent_bytes_next [4];
  logic [7:0]        function_byte_next;
  logic [7:0]        length_byte_next;
  logic [7:0]        error_byte_next;
  logic [SumW-1:0]   address_sum_next;
  logic [PayW-1:0]   payload_value_next;

  // State seen by the end-of-frame checks.
  logic [CountW-1:0] v_count;
  logic [15:0]       v_crc;
  logic [7:0]        v_recent [4];
  logic [7:0]        v_func;
  logic [7:0]        v_len;
  logic [7:0]        v_err;
  logic [SumW-1:0]   v_addr;
  logic [PayW-1:0]   v_payload;

  logic [SizeW-1:0]  eff_size;
  logic [CountW-1:0] max_count;
  logic [SumW-1:0]   addr_x100;
  logic [SumW-1:0]   digit_pair;
  logic              end_by_byte;
  logic              finish;
  logic              is_err;
  logic [CountW-1:0] want;

  // Payload size clamped into 1 .. MAX_PAYLOAD.
  always_comb begin
    if (cfg.payload_size == '0) begin
      eff_size = SizeW'(1);
    end else if (cfg.payload_size > SizeW'(MAX_PAYLOAD)) begin
      eff_size = SizeW'(MAX_PAYLOAD);
    end else begin
      eff_size = cfg.payload_size;
    end
    max_count = CountW'(eff_size) + FrameOverhead;
  end

  // Address accumulation: sum * 100 plus the two BCD digits of the byte.
  assign addr_x100 = (address_sum << 6) + (address_sum << 5) + (address_sum << 2);
  assign digit_pair = SumW'(rx_byte[3:0]) + (SumW'(rx_byte[7:4]) << 3)
                    + (SumW'(rx_byte[7:4]) << 1);

  // Next state for a received byte.
  always_comb begin
    byte_count_next  = byte_count + CountW'(1);
    running_crc_next = (byte_count >= CountW'(2)) ? crc16_byte(running_crc, recent_bytes[1])
                                                  : running_crc;
    recent_bytes_next[0] = rx_byte;
    recent_bytes_next[1] = recent_bytes[0];
    recent_bytes_next[2] = recent_bytes[1];
    recent_bytes_next[3] = recent_bytes[2];
    address_sum_next   = (byte_count < CountW'(4)) ? addr_x100 + digit_pair : address_sum;
    function_byte_next = (byte_count == CountW'(4)) ? rx_byte : function_byte;
    length_byte_next   = (byte_count == CountW'(5)) ? rx_byte : length_byte;
    error_byte_next    = (byte_count == CountW'(6)) ? rx_byte : error_byte;
    // One byte lane per payload position.
    payload_value_next = payload_value;
    for (int k = 0; k < MAX_PAYLOAD; k++) begin
      if (byte_count == CountW'(6 + k) && SizeW'(k) < eff_size) begin
        payload_value_next[8*k +: 8] = rx_byte;
      end
    end
    end_by_byte = (byte_count_next >= MinFrameLen && {3'b000, byte_count_next} == length_byte_next)
                || byte_count_next >= max_count;
  end

  // A gap checks the stored frame, a byte checks the frame including itself.
  always_comb begin
    if (cmd == CmdGap) begin
      v_count   = byte_count;
      v_crc     = running_crc;
      v_recent  = recent_bytes;
      v_func    = function_byte;
      v_len     = length_byte;
      v_err     = error_byte;
      v_addr    = address_sum;
      v_payload = payload_value;
      finish    = 1'b1;
    end else begin
      v_count   = byte_count_next;
      v_crc     = running_crc_next;
      v_recent  = recent_bytes_next;
      v_func    = function_byte_next;
      v_len     = length_byte_next;
      v_err     = error_byte_next;
      v_addr    = address_sum_next;
      v_payload = payload_value_next;
      finish    = end_by_byte;
    end
  end

  // End-of-frame checks in priority order.
  always_comb begin
    is_err = (v_func == FuncError);
    want   = is_err ? ErrFrameLen : max_count;
    res.status       = StOk;
    res.device_error = 8'h00;
    res.permanent    = 1'b0;
    res.value        = '0;
    if (v_count < MinFrameLen) begin
      res.status = StShort;
    end else if (v_count != want) begin
      res.status = StBadEnd;
    end else if ({3'b000, want} != v_len) begin
      res.status = StBadLength;
    end else if (v_crc != {v_recent[0], v_recent[1]}) begin
      res.status = StCrc;
    end else if (v_addr != {1'b0, cfg.slave_address}) begin
      res.status = StAddress;
    end else if ({v_recent[2], v_recent[3]} != cfg.request_id) begin
      res.status = StId;
    end else if (is_err) begin
      res.device_error = v_err;
      if (v_err <= MaxDevCode) begin
        res.status    = StDevError;
        res.permanent = (v_err == DevCodePermA) || (v_err == DevCodePermB);
      end else begin
        res.status = StDevCode;
      end
    end else begin
      res.value = ValueW'(v_payload);
    end
  end

  assign res_valid = in_fire && finish;

  // State update: clear after a result, otherwise take the byte.
  always_ff @(posedge clk) begin
    if (rst || (in_fire && finish)) begin
      byte_count    <= '0;
      running_crc   <= CrcInit;
      for (int i = 0; i < 4; i++) begin
        recent_bytes[i] <= 8'h00;
      end
      function_byte <= 8'h00;
      length_byte   <= 8'h00;
      error_byte    <= 8'h00;
      address_sum   <= '0;
      payload_value <= '0;
    end else if (in_fire) begin
      byte_count    <= byte_count_next;
      running_crc   <= running_crc_next;
      recent_bytes  <= recent_bytes_next;
      function_byte <= function_byte_next;
      length_byte   <= length_byte_next;
      error_byte    <= error_byte_next;
      address_sum   <= address_sum_next;
      payload_value <= payload_value_next;
    end
  end

endmodule

@@ rtl/meter_response_frame_checker_core.sv @@
// Meter response frame checker: received bytes of a meter reply in, one check result per frame out.
// The slave side carries bytes and gap marks, the master side carries results, plus a config port.
// A byte or gap is one transfer on the slave side; a frame ends on a gap, when the count
// reaches the length byte (count of six or more), or at payload size plus ten bytes.
// Slave side: s_tdata holds the received byte, s_tuser is 1 for a gap that ends the frame.
// Master side: one transfer per ended frame with status, device error code, permanent flag
// and the little-endian payload value.
// Config port: cfg_index selects slave address (0), request id (1) or payload size (2);
// cfg_ready is always high and a write takes effect at once; write only while idle.
// Throughput: one slave-side transfer every cycle while the skid register is not full. All checks
// of an item are combinational between the frame state registers and the result register.
// The result of the item that ends a frame goes to the output register, or to the skid register
// while the output register is held by a stall, and is offered on the master side from there.
// When the receiver stalls, one result sits in the output register and a second in a skid
// register; s_tready drops only while the skid register is full.
// Reset clears the frame state and the valid flags of both result registers and sets payload
// size to 8, slave address and request id to 0.
// Depends on mrfc_pkg and mrfc_frame_unit.
module meter_response_frame_checker_core
  import mrfc_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MaxPayloadDefault
) (
  input  logic                clk,
  input  logic                rst,
  // Slave side.
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [7:0] rx_byte
  input  logic                s_tuser,   // [0] cmd
  // Master side.
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,   // [3:0] status, [11:4] device_error,
                                         // [12] permanent, [76:13] value, rest zero
  // Configuration writes.
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [AddrW-1:0]    cfg_data
);

  cfg_t    cfg;
  logic    in_fire;
  logic    res_valid;
  result_t res;
  result_t out_res;
  result_t skid_res;
  logic    skid_valid;
  logic    pop;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slave_address <= '0;
      cfg.request_id    <= '0;
      cfg.payload_size  <= SizeW'(MaxPayloadDefault);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        RegSlaveAddress: cfg.slave_address <= cfg_data;
        RegRequestId:    cfg.request_id    <= cfg_data[IdW-1:0];
        RegPayloadSize:  cfg.payload_size  <= cfg_data[SizeW-1:0];
        default: ;
      endcase
    end
  end

  // Frame state and checks.
  assign s_tready = !skid_valid;
  assign in_fire  = s_tvalid && s_tready;

  mrfc_frame_unit #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_frame (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_fire  (in_fire),
    .cmd      (s_tuser),
    .rx_byte  (s_tdata),
    .res_valid(res_valid),
    .res      (res)
  );

  // Output register with a skid register behind it.
  assign pop = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (!m_tvalid || pop) begin
        out_res  <= res;
        m_tvalid <= 1'b1;
      end else begin
        skid_res   <= res;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = OutDataW'(out_res);

endmodule

@@ dv/tb_meter_response_frame_checker_core.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for meter_response_frame_checker_core: a directed frame table,
// then random replies, noise and faults, all scored against a built-in frame predictor.
// Depends on mrfc_pkg and the meter_response_frame_checker_core RTL.
module tb_meter_response_frame_checker_core;
  import mrfc_pkg::*;

  localparam int unsigned PayloadCap  = MaxPayloadDefault;
  localparam int unsigned RandomItems = 920;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned ShowLimit   = 10;

  // Kinds of rows in the directed table.
  typedef enum logic [2:0] {
    RowCfg, RowGap, RowByte, RowOpen, RowReply, RowErrReply
  } row_kind_e;

  // Ways a generated reply is damaged.
  typedef enum logic [2:0] {
    FaultNone, FaultShort, FaultEnd, FaultLength, FaultCrc, FaultAddress, FaultId, FaultNibble
  } frame_fault_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
  } rx_item_t;

  // For RowOpen the code field is the number of bytes sent, for RowByte it is the byte.
  typedef struct packed {
    row_kind_e          kind;
    frame_fault_e       fault;
    logic [63:0]        payload;
    logic [7:0]         code;
    logic [CfgIdxW-1:0] reg_idx;
    logic [AddrW-1:0]   reg_val;
    logic               typed;
    result_t            report;
  } plan_row_t;

  localparam result_t NoReport = '0;

  logic                clk;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata = 8'h00;
  logic                s_tuser = CmdByte;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = RegSlaveAddress;
  logic [AddrW-1:0]    cfg_data = '0;

  meter_response_frame_checker_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register copies seen by the predictor.
  logic [AddrW-1:0] want_addr = '0;
  logic [15:0]      want_id   = '0;
  logic [3:0]       size_reg  = SizeW'(MaxPayloadDefault);

  // Frame state of the predictor.
  logic [4:0]  fr_count = '0;
  logic [15:0] fr_crc   = CrcInit;
  logic [7:0]  fr_tail [4];
  logic [7:0]  fr_func  = 8'h00;
  logic [7:0]  fr_len   = 8'h00;
  logic [7:0]  fr_code  = 8'h00;
  logic [63:0] fr_addr  = '0;
  logic [63:0] fr_value = '0;

  result_t     expected_reports [$];
  plan_row_t   plan [$];
  rx_item_t    burst [$];
  logic        typed_armed = 1'b0;
  result_t     typed_report;
  bit          steady = 1'b0;
  int unsigned items_sent = 0;
  int unsigned fail_count = 0;
  int unsigned shown = 0;
  int unsigned cycle_count = 0;
  result_t     mon_want;
  result_t     mon_got;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    for (int k = 0; k < 4; k++) fr_tail[k] = 8'h00;
  end

  // Reflected CRC-16, one input bit per step.
  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic fb;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c = {1'b0, c[15:1]} ^ (fb ? CrcPoly : 16'h0000);
    end
    return c;
  endfunction

  function automatic int unsigned size_in_use();
    if (size_reg == 0) return 1;
    if (size_reg > PayloadCap) return PayloadCap;
    return size_reg;
  endfunction

  function automatic logic [31:0] to_bcd(input int unsigned v);
    logic [31:0] r;
    for (int k = 0; k < 8; k++) begin
      r[4*k +: 4] = 4'(v % 10);
      v = v / 10;
    end
    return r;
  endfunction

  // Checks the collected frame in order, queues the report and clears the frame.
  function automatic void close_report();
    result_t     r;
    int unsigned want_len;
    r = '0;
    want_len = (fr_func == FuncError) ? ErrFrameLen : size_in_use() + 10;
    if (fr_count < MinFrameLen) begin
      r.status = StShort;
    end else if (fr_count != want_len) begin
      r.status = StBadEnd;
    end else if (want_len != fr_len) begin
      r.status = StBadLength;
    end else if (fr_crc != {fr_tail[0], fr_tail[1]}) begin
      r.status = StCrc;
    end else if (fr_addr != {37'd0, want_addr}) begin
      r.status = StAddress;
    end else if ({fr_tail[2], fr_tail[3]} != want_id) begin
      r.status = StId;
    end else if (fr_func == FuncError) begin
      r.device_error = fr_code;
      if (fr_code <= MaxDevCode) begin
        r.status = StDevError;
        r.permanent = (fr_code == DevCodePermA) || (fr_code == DevCodePermB);
      end else begin
        r.status = StDevCode;
      end
    end else begin
      r.status = StOk;
      r.value = fr_value;
    end
    if (typed_armed) begin
      r = typed_report;
      typed_armed = 1'b0;
    end
    expected_reports.push_back(r);
    fr_count = '0;
    fr_crc = CrcInit;
    for (int k = 0; k < 4; k++) fr_tail[k] = 8'h00;
    fr_func = 8'h00;
    fr_len = 8'h00;
    fr_code = 8'h00;
    fr_addr = '0;
    fr_value = '0;
  endfunction

  // Advances the predictor by one accepted transfer.
  function automatic void predict_rx(input logic cmd, input logic [7:0] data);
    int unsigned idx;
    int unsigned lim;
    if (cmd == CmdGap) begin
      close_report();
    end else begin
      idx = fr_count;
      lim = size_in_use();
      // The CRC trails by two bytes so that the received CRC stays out of it.
      if (idx >= 2) fr_crc = crc16_step(fr_crc, fr_tail[1]);
      fr_tail[3] = fr_tail[2];
      fr_tail[2] = fr_tail[1];
      fr_tail[1] = fr_tail[0];
      fr_tail[0] = data;
      if (idx < 4) fr_addr = fr_addr * 100 + data[3:0] + 10 * data[7:4];
      else if (idx == 4) fr_func = data;
      else if (idx == 5) fr_len = data;
      if (idx == 6) fr_code = data;
      if (idx >= 6 && idx < 6 + lim) fr_value |= {56'd0, data} << (8 * (idx - 6));
      fr_count = 5'(idx + 1);
      if ((fr_count >= MinFrameLen && fr_count == fr_len) || fr_count >= lim + 10) begin
        close_report();
      end
    end
  endfunction

  function automatic result_t rep(input logic [StatusW-1:0] st, input logic [7:0] dev,
                                  input logic perm, input logic [63:0] val);
    result_t r;
    r.status = st;
    r.device_error = dev;
    r.permanent = perm;
    r.value = val;
    return r;
  endfunction

  function automatic plan_row_t reply_row(input row_kind_e kind, input frame_fault_e fault,
                                          input logic [63:0] payload, input logic [7:0] code,
                                          input logic typed, input result_t report);
    plan_row_t r;
    r = '0;
    r.kind = kind;
    r.fault = fault;
    r.payload = payload;
    r.code = code;
    r.typed = typed;
    r.report = report;
    return r;
  endfunction

  function automatic plan_row_t reg_row(input logic [CfgIdxW-1:0] idx,
                                        input logic [AddrW-1:0] val);
    plan_row_t r;
    r = '0;
    r.kind = RowCfg;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // Offers one item after a random idle gap and waits for its transfer.
  task automatic send_rx(input logic cmd, input logic [7:0] data);
    while (!steady && $urandom_range(99) < 31) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_rx(cmd, data);
    items_sent++;
  endtask

  // Waits until the block has nothing left to deliver, then writes one register.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [AddrW-1:0] val);
    s_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      RegSlaveAddress: want_addr = val;
      RegRequestId:    want_id = val[15:0];
      RegPayloadSize:  size_reg = val[3:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Builds the bytes of one reply for the current registers into burst.
  task automatic compose_reply(input logic err, input frame_fault_e fault,
                               input logic [63:0] payload, input logic [7:0] code);
    int unsigned n_pay;
    int unsigned a;
    int unsigned cut;
    logic [31:0] bcd;
    logic [15:0] id;
    logic [15:0] crc;
    logic [7:0]  raw [$];
    rx_item_t    it;
    n_pay = size_in_use();
    a = want_addr;
    if (fault == FaultAddress) a = (a + 1) % 100000000;
    bcd = to_bcd(a);
    if (fault == FaultNibble) bcd = 32'hABCD_EFFA;
    for (int k = 3; k >= 0; k--) raw.push_back(bcd[8*k +: 8]);
    raw.push_back(err ? FuncError : 8'($urandom_range(1, 255)));
    if (fault == FaultLength) raw.push_back(8'd200);
    else raw.push_back(err ? {3'b000, ErrFrameLen} : 8'(n_pay + 10));
    if (err) raw.push_back(code);
    else for (int k = 0; k < n_pay; k++) raw.push_back(payload[8*k +: 8]);
    id = want_id;
    if (fault == FaultId) id = id + 16'd1;
    raw.push_back(id[7:0]);
    raw.push_back(id[15:8]);
    crc = CrcInit;
    foreach (raw[k]) crc = crc16_step(crc, raw[k]);
    if (fault == FaultCrc) crc = crc ^ 16'h8000;
    raw.push_back(crc[7:0]);
    raw.push_back(crc[15:8]);
    cut = raw.size();
    if (fault == FaultShort) cut = $urandom_range(5);
    if (fault == FaultEnd) cut = $urandom_range(6, raw.size() - 1);
    burst.delete();
    for (int k = 0; k < cut; k++) begin
      it.cmd = CmdByte;
      it.data = raw[k];
      burst.push_back(it);
    end
    if (fault == FaultShort || fault == FaultEnd) begin
      it.cmd = CmdGap;
      it.data = 8'($urandom);
      burst.push_back(it);
    end
  endtask

  task automatic play_burst(input int unsigned n);
    for (int k = 0; k < n && k < burst.size(); k++) send_rx(burst[k].cmd, burst[k].data);
  endtask

  // A gap ends whatever frame is still being collected.
  task automatic close_open_frame();
    if (fr_count != 0) send_rx(CmdGap, 8'($urandom));
  endtask

  task automatic run_frame(input logic err, input frame_fault_e fault,
                           input logic [63:0] payload, input logic [7:0] code);
    compose_reply(err, fault, payload, code);
    play_burst(burst.size());
    close_open_frame();
  endtask

  // Receiver side: accepts results with random stalls.
  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= 31);
  end

  // Result scoreboard.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      mon_got = m_tdata[ResultW-1:0];
      if (expected_reports.size() == 0) begin
        fail_count++;
        if (shown < ShowLimit) begin
          shown++;
          $display("unexpected result: status %0d dev %0d perm %0d value %h",
                   mon_got.status, mon_got.device_error, mon_got.permanent, mon_got.value);
        end
      end else begin
        mon_want = expected_reports.pop_front();
        if (mon_got.status != mon_want.status || mon_got.device_error != mon_want.device_error
            || mon_got.permanent != mon_want.permanent || mon_got.value != mon_want.value
            || m_tdata[OutDataW-1:ResultW] != '0) begin
          fail_count++;
          if (shown < ShowLimit) begin
            shown++;
            $display("result mismatch: expected status %0d dev %0d perm %0d value %h",
                     mon_want.status, mon_want.device_error, mon_want.permanent,
                     mon_want.value);
            $display("                 got      status %0d dev %0d perm %0d value %h pad %h",
                     mon_got.status, mon_got.device_error, mon_got.permanent,
                     mon_got.value, m_tdata[OutDataW-1:ResultW]);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("[meter_response_frame_checker_core] ERROR");
      $finish;
    end
  end

  // Stimulus: directed table, then random replies in several register settings.
  initial begin
    int unsigned base;
    int unsigned done;
    int unsigned next_cfg;
    int unsigned phase;
    int unsigned pick;
    int unsigned drain;
    logic [63:0] payload;
    logic [7:0]  code;

    // Reset values first: slave address 0, request id 0, payload size 8.
    plan.push_back(reply_row(RowGap, FaultNone, '0, 8'h00, 1'b1, rep(StShort, 8'h00, 1'b0, '0)));
    plan.push_back(reply_row(RowReply, FaultNone, 64'h0123_4567_89AB_CDEF, 8'h00, 1'b1,
                             rep(StOk, 8'h00, 1'b0, 64'h0123_4567_89AB_CDEF)));
    plan.push_back(reg_row(RegSlaveAddress, 27'd99999999));
    plan.push_back(reg_row(RegRequestId, 27'hFFFF));
    plan.push_back(reply_row(RowReply, FaultNone, '1, 8'h00, 1'b1, rep(StOk, 8'h00, 1'b0, '1)));
    plan.push_back(reply_row(RowReply, FaultNone, '0, 8'h00, 1'b1, rep(StOk, 8'h00, 1'b0, '0)));
    // Device error frames: permanent codes, the edges of the valid range and beyond.
    plan.push_back(reply_row(RowErrReply, FaultNone, '0, 8'd2, 1'b1,
                             rep(StDevError, 8'd2, 1'b1, '0)));
    plan.push_back(reply_row(RowErrReply, FaultNone, '0, 8'd4, 1'b1,
                             rep(StDevError, 8'd4, 1'b1, '0)));
    plan.push_back(reply_row(RowErrReply, FaultNone, '0, 8'd0, 1'b1,
                             rep(StDevError, 8'd0, 1'b0, '0)));
    plan.push_back(reply_row(RowErrReply, FaultNone, '0, 8'd8, 1'b1,
                             rep(StDevError, 8'd8, 1'b0, '0)));
    plan.push_back(reply_row(RowErrReply, FaultNone, '0, 8'd9, 1'b1,
                             rep(StDevCode, 8'd9, 1'b0, '0)));
    plan.push_back(reply_row(RowErrReply, FaultNone, '0, 8'd255, 1'b1,
                             rep(StDevCode, 8'd255, 1'b0, '0)));
    // Every failing check, in check order.
    plan.push_back(reply_row(RowReply, FaultShort, '1, 8'h00, 1'b1, rep(StShort, 8'h00, 1'b0, '0)));
    plan.push_back(reply_row(RowReply, FaultEnd, '1, 8'h00, 1'b1, rep(StBadEnd, 8'h00, 1'b0, '0)));
    plan.push_back(reply_row(RowReply, FaultLength, '1, 8'h00, 1'b1,
                             rep(StBadLength, 8'h00, 1'b0, '0)));
    plan.push_back(reply_row(RowReply, FaultCrc, '1, 8'h00, 1'b1, rep(StCrc, 8'h00, 1'b0, '0)));
    plan.push_back(reply_row(RowReply, FaultAddress, '1, 8'h00, 1'b1,
                             rep(StAddress, 8'h00, 1'b0, '0)));
    plan.push_back(reply_row(RowReply, FaultNibble, '1, 8'h00, 1'b1,
                             rep(StAddress, 8'h00, 1'b0, '0)));
    plan.push_back(reply_row(RowReply, FaultId, '1, 8'h00, 1'b1, rep(StId, 8'h00, 1'b0, '0)));
    // Payload size out of range on both sides.
    plan.push_back(reg_row(RegPayloadSize, 27'd0));
    plan.push_back(reply_row(RowReply, FaultNone, 64'h8000_0000_0000_00A5, 8'h00, 1'b0, NoReport));
    plan.push_back(reg_row(RegPayloadSize, 27'd15));
    plan.push_back(reply_row(RowReply, FaultNone, 64'h5A5A_0F0F_F0F0_A5A5, 8'h00, 1'b0, NoReport));
    // Size shrunk while a frame is open: the next byte ends it.
    plan.push_back(reply_row(RowOpen, FaultNone, 64'h1122_3344_5566_7788, 8'd13, 1'b0, NoReport));
    plan.push_back(reg_row(RegPayloadSize, 27'd2));
    plan.push_back(reply_row(RowByte, FaultNone, '0, 8'h5A, 1'b0, NoReport));
    plan.push_back(reply_row(RowErrReply, FaultLength, '0, 8'd3, 1'b0, NoReport));
    plan.push_back(reg_row(RegPayloadSize, 27'd8));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      typed_armed = plan[i].typed;
      typed_report = plan[i].report;
      case (plan[i].kind)
        RowCfg:      write_reg(plan[i].reg_idx, plan[i].reg_val);
        RowGap:      send_rx(CmdGap, 8'($urandom));
        RowByte:     send_rx(CmdByte, plan[i].code);
        RowOpen: begin
          compose_reply(1'b0, FaultNone, plan[i].payload, 8'h00);
          play_burst(plan[i].code);
        end
        RowReply:    run_frame(1'b0, plan[i].fault, plan[i].payload, plan[i].code);
        RowErrReply: run_frame(1'b1, plan[i].fault, plan[i].payload, plan[i].code);
        default: ;
      endcase
    end
    typed_armed = 1'b0;

    // Random part: mostly well-formed replies, some faults, noise and bare gaps.
    base = items_sent;
    next_cfg = 0;
    phase = 0;
    done = 0;
    while (done < RandomItems) begin
      steady = (done >= 400 && done < 650);
      if (done >= next_cfg) begin
        close_open_frame();
        case (phase)
          0: begin
            write_reg(RegSlaveAddress, 27'd0);
            write_reg(RegRequestId, 27'd0);
            write_reg(RegPayloadSize, 27'd1);
          end
          1: begin
            write_reg(RegSlaveAddress, 27'd99999999);
            write_reg(RegRequestId, 27'hFFFF);
            write_reg(RegPayloadSize, 27'd8);
          end
          default: begin
            case ($urandom_range(3))
              0:       write_reg(RegSlaveAddress, 27'd0);
              1:       write_reg(RegSlaveAddress, 27'd99999999);
              default: write_reg(RegSlaveAddress, 27'($urandom_range(99999999)));
            endcase
            case ($urandom_range(3))
              0:       write_reg(RegRequestId, 27'd0);
              1:       write_reg(RegRequestId, 27'hFFFF);
              default: write_reg(RegRequestId, 27'($urandom_range(16'hFFFF)));
            endcase
            write_reg(RegPayloadSize, 27'($urandom_range(15)));
          end
        endcase
        phase++;
        next_cfg = done + 120 + $urandom_range(80);
      end
      payload = {$urandom, $urandom};
      if ($urandom_range(9) == 0) payload = $urandom_range(1) ? '1 : '0;
      code = $urandom_range(1) ? 8'($urandom_range(8)) : 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 55) begin
        run_frame(1'b0, FaultNone, payload, code);
      end else if (pick < 70) begin
        run_frame(1'b1, FaultNone, payload, code);
      end else if (pick < 88) begin
        run_frame($urandom_range(1),
                  frame_fault_e'($urandom_range(int'(FaultShort), int'(FaultNibble))),
                  payload, code);
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 24)) send_rx(CmdByte, 8'($urandom));
        close_open_frame();
      end else begin
        send_rx(CmdGap, 8'($urandom));
      end
      done = items_sent - base;
    end
    steady = 1'b0;
    close_open_frame();
    s_tvalid <= 1'b0;

    // Let the last results drain, then let the block run on before the final check.
    drain = 0;
    while (expected_reports.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    fail_count += expected_reports.size();
    if (fail_count == 0) begin
      $display("[meter_response_frame_checker_core] OK");
    end else begin
      $display("[meter_response_frame_checker_core] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/mrfc_pkg.sv
rtl/mrfc_frame_unit.sv
rtl/meter_response_frame_checker_core.sv
dv/tb_meter_response_frame_checker_core.sv
